/* sv/imasm_pkg.sv */
// shared types, constants and helper functions for the integer matrix engine
package imasm_pkg;

    localparam int unsigned MAX_DIM_DEFAULT = 8;
    localparam int unsigned DIM_W           = 4;
    localparam int unsigned DATA_W          = 32;
    localparam int unsigned POS_W           = 3;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CFG_OPERATION = 2'd0,
        CFG_ROWS_A    = 2'd1,
        CFG_COLS_A    = 2'd2,
        CFG_COLS_B    = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        CMD_FIRST  = 1'b0,
        CMD_SECOND = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ISSUE,
        BK_WAIT,
        BK_PUSH
    } back_state_t;

    typedef struct packed {
        logic                     cmd;
        logic signed [DATA_W-1:0] element_value;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [POS_W-1:0]         result_row;
        logic [POS_W-1:0]         result_col;
        logic                     last;
    } result_t;

    // one result matrix to compute, shapes already clamped
    typedef struct packed {
        logic             mul;
        logic             sub;
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols_a;
        logic [DIM_W-1:0] cols_b;
    } job_t;

    function automatic int unsigned addr_w(int unsigned max_dim);
        int unsigned depth;
        depth = max_dim * max_dim;
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic int unsigned cnt_w(int unsigned max_dim);
        return $clog2(max_dim * max_dim + 1);
    endfunction

    function automatic int unsigned ptr_w(int unsigned max_dim);
        return $clog2(max_dim * max_dim + max_dim);
    endfunction

    // zero acts as one, anything above the limit acts as the limit
    function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] d, logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        if (d == '0)
        begin
            r = DIM_W'(1);
        end
        else if (d > lim)
        begin
            r = lim;
        end
        else
        begin
            r = d;
        end
        return r;
    endfunction

endpackage

/* sv/imasm_if.sv */
// valid/ready channels for input words and result words
interface imasm_item_if;
    logic                valid;
    logic                ready;
    imasm_pkg::item_t    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface imasm_result_if;
    logic                valid;
    logic                ready;
    imasm_pkg::result_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/imasm_ram.sv */
// generic single-write, single-read ram with registered read data
module imasm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

/* sv/imasm_front.sv */
// front end: config registers, element loading and result job launch
module imasm_front #(
    parameter int unsigned MAX_DIM = imasm_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    imasm_item_if.sink                                 item,
    input  logic                                       cfg_we,
    input  logic [1:0]                                 cfg_index,
    input  logic [imasm_pkg::DIM_W-1:0]                cfg_data,
    output logic                                       a_we,
    output logic [imasm_pkg::addr_w(MAX_DIM)-1:0]      a_waddr,
    output logic [imasm_pkg::DATA_W-1:0]               a_wdata,
    output logic                                       b_we,
    output logic [imasm_pkg::addr_w(MAX_DIM)-1:0]      b_waddr,
    output logic [imasm_pkg::DATA_W-1:0]               b_wdata,
    output logic                                       job_valid,
    input  logic                                       job_ready,
    output imasm_pkg::job_t                            job,
    input  logic                                       job_done
);

    localparam int unsigned DIM_W  = imasm_pkg::DIM_W;
    localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
    localparam int unsigned ADDR_W = imasm_pkg::addr_w(MAX_DIM);
    localparam int unsigned CNT_W  = imasm_pkg::cnt_w(MAX_DIM);
    localparam int unsigned SIZE_W = 2 * DIM_W;
    localparam int unsigned CMP_W  = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam logic [DIM_W-1:0] LIM = DIM_W'((MAX_DIM > 15) ? 15 : MAX_DIM);

    logic [1:0]        op_reg;
    logic [DIM_W-1:0]  rows_reg;
    logic [DIM_W-1:0]  cols_a_reg;
    logic [DIM_W-1:0]  cols_b_reg;
    logic [CNT_W-1:0]  first_cnt_reg;
    logic [CNT_W-1:0]  first_cnt_next;
    logic [CNT_W-1:0]  second_cnt_reg;
    logic [CNT_W-1:0]  second_cnt_next;
    logic              busy_reg;
    logic              busy_next;

    logic [DIM_W-1:0]  ra;
    logic [DIM_W-1:0]  ca;
    logic [DIM_W-1:0]  cb;
    logic              mul;
    logic              sub;
    logic [SIZE_W-1:0] size_a;
    logic [SIZE_W-1:0] size_b;
    logic [CNT_W-1:0]  second_inc;
    logic              accept;
    logic              is_second;
    logic              trigger;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg     <= imasm_pkg::OP_ADD;
            rows_reg   <= imasm_pkg::DIM_RESET;
            cols_a_reg <= imasm_pkg::DIM_RESET;
            cols_b_reg <= imasm_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (imasm_pkg::cfg_reg_t'(cfg_index))
                imasm_pkg::CFG_OPERATION: op_reg     <= cfg_data[1:0];
                imasm_pkg::CFG_ROWS_A:    rows_reg   <= cfg_data;
                imasm_pkg::CFG_COLS_A:    cols_a_reg <= cfg_data;
                imasm_pkg::CFG_COLS_B:    cols_b_reg <= cfg_data;
                default:                  op_reg     <= op_reg;
            endcase
        end
    end

    always_comb
    begin
        ra     = imasm_pkg::eff_dim(rows_reg, LIM);
        ca     = imasm_pkg::eff_dim(cols_a_reg, LIM);
        cb     = imasm_pkg::eff_dim(cols_b_reg, LIM);
        // the unused code behaves as multiply
        mul    = (op_reg != imasm_pkg::OP_ADD) && (op_reg != imasm_pkg::OP_SUB);
        sub    = (op_reg == imasm_pkg::OP_SUB);
        size_a = SIZE_W'(ra) * SIZE_W'(ca);
        size_b = mul ? (SIZE_W'(ca) * SIZE_W'(cb)) : size_a;
    end

    assign item.ready = !busy_reg && job_ready;
    assign accept     = item.valid && item.ready;
    assign is_second  = (item.payload.cmd == imasm_pkg::CMD_SECOND);
    assign second_inc = second_cnt_reg + CNT_W'(1);
    assign trigger    = accept && is_second && (CMP_W'(second_inc) >= CMP_W'(size_b));

    // store writes
    assign a_we    = accept && !is_second && (CMP_W'(first_cnt_reg) < CMP_W'(size_a));
    assign a_waddr = first_cnt_reg[ADDR_W-1:0];
    assign a_wdata = item.payload.element_value;
    assign b_we    = accept && is_second && (CMP_W'(second_cnt_reg) < CMP_W'(DEPTH));
    assign b_waddr = second_cnt_reg[ADDR_W-1:0];
    assign b_wdata = item.payload.element_value;

    assign job_valid  = trigger;
    assign job.mul    = mul;
    assign job.sub    = sub;
    assign job.rows   = ra;
    assign job.cols_a = ca;
    assign job.cols_b = cb;

    always_comb
    begin
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        busy_next       = busy_reg;
        if (a_we)
        begin
            first_cnt_next = first_cnt_reg + CNT_W'(1);
        end
        if (accept && is_second)
        begin
            second_cnt_next = second_inc;
        end
        if (trigger)
        begin
            first_cnt_next  = '0;
            second_cnt_next = '0;
            busy_next       = 1'b1;
        end
        else if (job_done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            busy_reg       <= 1'b0;
        end
        else
        begin
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            busy_reg       <= busy_next;
        end
    end

endmodule

/* sv/imasm_job_fifo.sv */
// two-entry job queue between the front and back ends
module imasm_job_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  imasm_pkg::job_t  push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output imasm_pkg::job_t  pop_data
);

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    imasm_pkg::job_t    mem_reg [QDEPTH];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

/* sv/imasm_back.sv */
// back end: walks the result matrix, reads both stores and accumulates
module imasm_back #(
    parameter int unsigned MAX_DIM = imasm_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   job_valid,
    output logic                                   job_ready,
    input  imasm_pkg::job_t                        job,
    output logic                                   rd_en,
    output logic [imasm_pkg::addr_w(MAX_DIM)-1:0]  a_raddr,
    input  logic [imasm_pkg::DATA_W-1:0]           a_rdata,
    output logic [imasm_pkg::addr_w(MAX_DIM)-1:0]  b_raddr,
    input  logic [imasm_pkg::DATA_W-1:0]           b_rdata,
    output logic                                   job_done,
    imasm_result_if.source                         result
);

    localparam int unsigned DIM_W  = imasm_pkg::DIM_W;
    localparam int unsigned DATA_W = imasm_pkg::DATA_W;
    localparam int unsigned POS_W  = imasm_pkg::POS_W;
    localparam int unsigned ADDR_W = imasm_pkg::addr_w(MAX_DIM);
    localparam int unsigned PTR_W  = imasm_pkg::ptr_w(MAX_DIM);

    imasm_pkg::back_state_t state_reg;
    imasm_pkg::back_state_t state_next;

    imasm_pkg::job_t   job_reg;
    imasm_pkg::job_t   job_next;
    logic [DIM_W-1:0]  i_reg;
    logic [DIM_W-1:0]  i_next;
    logic [DIM_W-1:0]  j_reg;
    logic [DIM_W-1:0]  j_next;
    logic [DIM_W-1:0]  t_reg;
    logic [DIM_W-1:0]  t_next;
    logic [PTR_W-1:0]  a_base_reg;
    logic [PTR_W-1:0]  a_base_next;
    logic [PTR_W-1:0]  b_base_reg;
    logic [PTR_W-1:0]  b_base_next;
    logic [PTR_W-1:0]  a_ptr_reg;
    logic [PTR_W-1:0]  a_ptr_next;
    logic [PTR_W-1:0]  b_ptr_reg;
    logic [PTR_W-1:0]  b_ptr_next;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_next;

    logic              rd_vld_reg;
    logic              rd_last_reg;
    logic              prod_vld_reg;
    logic              prod_last_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] prod_next;

    logic               out_vld_reg;
    logic               out_vld_next;
    imasm_pkg::result_t out_data_reg;

    logic              start_job;
    logic              load_out;
    logic              out_free;
    logic [DIM_W-1:0]  rc;
    logic [DIM_W-1:0]  inner;
    logic              issue_last;
    logic              j_last;
    logic              i_last;
    logic              elem_final;
    logic [PTR_W-1:0]  b_step;

    assign rc         = job_reg.mul ? job_reg.cols_b : job_reg.cols_a;
    assign inner      = job_reg.mul ? job_reg.cols_a : DIM_W'(1);
    assign issue_last = (DIM_W'(t_reg + DIM_W'(1)) == inner);
    assign j_last     = (DIM_W'(j_reg + DIM_W'(1)) == rc);
    assign i_last     = (DIM_W'(i_reg + DIM_W'(1)) == job_reg.rows);
    assign elem_final = i_last && j_last;
    assign b_step     = job_reg.mul ? PTR_W'(job_reg.cols_b) : PTR_W'(1);
    assign out_free   = !out_vld_reg || result.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            imasm_pkg::BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = imasm_pkg::BK_ISSUE;
                end
            end
            imasm_pkg::BK_ISSUE:
            begin
                if (issue_last)
                begin
                    state_next = imasm_pkg::BK_WAIT;
                end
            end
            imasm_pkg::BK_WAIT:
            begin
                if (prod_vld_reg && prod_last_reg)
                begin
                    state_next = imasm_pkg::BK_PUSH;
                end
            end
            imasm_pkg::BK_PUSH:
            begin
                if (out_free)
                begin
                    state_next = elem_final ? imasm_pkg::BK_IDLE : imasm_pkg::BK_ISSUE;
                end
            end
            default:
            begin
                state_next = imasm_pkg::BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        job_ready = 1'b0;
        rd_en     = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            imasm_pkg::BK_IDLE:  job_ready = 1'b1;
            imasm_pkg::BK_ISSUE: rd_en     = 1'b1;
            imasm_pkg::BK_WAIT:  job_ready = 1'b0;
            imasm_pkg::BK_PUSH:  load_out  = out_free;
            default:             job_ready = 1'b0;
        endcase
    end

    assign start_job = job_ready && job_valid;
    assign job_done  = load_out && elem_final;
    assign a_raddr   = a_ptr_reg[ADDR_W-1:0];
    assign b_raddr   = b_ptr_reg[ADDR_W-1:0];

    // walk counters and accumulator
    always_comb
    begin
        job_next    = job_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        t_next      = t_reg;
        a_base_next = a_base_reg;
        b_base_next = b_base_reg;
        a_ptr_next  = a_ptr_reg;
        b_ptr_next  = b_ptr_reg;
        acc_next    = acc_reg;

        if (start_job)
        begin
            job_next    = job;
            i_next      = '0;
            j_next      = '0;
            t_next      = '0;
            a_base_next = '0;
            b_base_next = '0;
            a_ptr_next  = '0;
            b_ptr_next  = '0;
            acc_next    = '0;
        end

        if (rd_en)
        begin
            a_ptr_next = a_ptr_reg + PTR_W'(1);
            b_ptr_next = b_ptr_reg + b_step;
            t_next     = issue_last ? '0 : DIM_W'(t_reg + DIM_W'(1));
        end

        if (prod_vld_reg)
        begin
            acc_next = acc_reg + prod_reg;
        end

        if (load_out)
        begin
            acc_next = '0;
            if (j_last)
            begin
                j_next = '0;
                i_next = DIM_W'(i_reg + DIM_W'(1));
            end
            else
            begin
                j_next = DIM_W'(j_reg + DIM_W'(1));
            end
            if (job_reg.mul)
            begin
                // product: row base moves by the inner size, column base restarts
                if (j_last)
                begin
                    a_base_next = a_base_reg + PTR_W'(job_reg.cols_a);
                    b_base_next = '0;
                end
                else
                begin
                    b_base_next = b_base_reg + PTR_W'(1);
                end
            end
            else
            begin
                a_base_next = a_base_reg + PTR_W'(1);
                b_base_next = b_base_reg + PTR_W'(1);
            end
            a_ptr_next = a_base_next;
            b_ptr_next = b_base_next;
        end
    end

    always_comb
    begin
        if (job_reg.mul)
        begin
            prod_next = a_rdata * b_rdata;
        end
        else if (job_reg.sub)
        begin
            prod_next = a_rdata - b_rdata;
        end
        else
        begin
            prod_next = a_rdata + b_rdata;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (load_out)
        begin
            out_vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= imasm_pkg::BK_IDLE;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            t_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_en;
            rd_last_reg   <= rd_en && issue_last;
            prod_vld_reg  <= rd_vld_reg;
            prod_last_reg <= rd_last_reg;
            out_vld_reg   <= out_vld_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            t_reg         <= t_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        a_base_reg <= a_base_next;
        b_base_reg <= b_base_next;
        a_ptr_reg  <= a_ptr_next;
        b_ptr_reg  <= b_ptr_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        if (load_out)
        begin
            out_data_reg.result_value <= acc_reg;
            out_data_reg.result_row   <= i_reg[POS_W-1:0];
            out_data_reg.result_col   <= j_reg[POS_W-1:0];
            out_data_reg.last         <= elem_final;
        end
    end

    assign result.valid   = out_vld_reg;
    assign result.payload = out_data_reg;

endmodule

/* sv/int_matrix_add_sub_mul.sv */
// top level of the integer matrix add, subtract and multiply engine
//
// load the first matrix (cmd 0) and then the second (cmd 1) one word per cycle,
// row-major; the word that completes the second matrix launches the result,
// which leaves row-major on the result channel with its row, column and a last
// flag, wrapped to 32 bits. the input is held off (ready low) from that word
// until the final result word has been handed to the output register. each
// result word reads inner words from each store, where inner is cols_a for
// multiply and 1 for add or subtract: one read of each store per cycle feeds
// a single multiply/add stage and an accumulator, and the read, operate and
// accumulate stages drain before the word is posted to the output register,
// which waits while the result channel stalls; the next word is read only
// after that. configuration must be written only while no result is pending;
// the block itself does not enforce this. dimensions of 0 act as 1, values
// above MAX_DIM as MAX_DIM, and operation code 3 acts as multiply.
module int_matrix_add_sub_mul #(
    parameter int unsigned MAX_DIM = imasm_pkg::MAX_DIM_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    imasm_item_if.sink                   item,
    imasm_result_if.source               result,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [imasm_pkg::DIM_W-1:0]  cfg_data
);

    localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
    localparam int unsigned ADDR_W = imasm_pkg::addr_w(MAX_DIM);
    localparam int unsigned DATA_W = imasm_pkg::DATA_W;

    // store write ports from the front end
    logic              a_we;
    logic [ADDR_W-1:0] a_waddr;
    logic [DATA_W-1:0] a_wdata;
    logic              b_we;
    logic [ADDR_W-1:0] b_waddr;
    logic [DATA_W-1:0] b_wdata;

    // store read ports from the back end, both stores read in lockstep
    logic              rd_en;
    logic [ADDR_W-1:0] a_raddr;
    logic [DATA_W-1:0] a_rdata;
    logic [ADDR_W-1:0] b_raddr;
    logic [DATA_W-1:0] b_rdata;

    // job hand-off
    logic              push_valid;
    logic              push_ready;
    imasm_pkg::job_t   push_job;
    logic              pop_valid;
    logic              pop_ready;
    imasm_pkg::job_t   pop_job;
    logic              job_done;

    // front end: registers, load counters, launch on the closing word
    imasm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .a_we      (a_we),
        .a_waddr   (a_waddr),
        .a_wdata   (a_wdata),
        .b_we      (b_we),
        .b_waddr   (b_waddr),
        .b_wdata   (b_wdata),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_job),
        .job_done  (job_done)
    );

    // short queue decoupling launch from the walk
    imasm_job_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_job)
    );

    // first matrix store
    imasm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_first_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .re    (rd_en),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    // second matrix store
    imasm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_second_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (rd_en),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // back end: result walk, arithmetic and output register
    imasm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .rd_en     (rd_en),
        .a_raddr   (a_raddr),
        .a_rdata   (a_rdata),
        .b_raddr   (b_raddr),
        .b_rdata   (b_rdata),
        .job_done  (job_done),
        .result    (result)
    );

endmodule
